>>> design/ptsb_pkg.sv
// ----------------------------------------------------------------------------
// ptsb_pkg: shared definitions for the periodic timer slot bank
// Widths, opcodes, result kinds and the controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ptsb_pkg;

  localparam int SLOTS  = 8;
  localparam int IDX_W  = 3;
  localparam int EV_W   = 8;
  localparam int CNT_W  = 32;
  localparam int OP_W   = 3;
  localparam int KIND_W = 3;

  // opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
  localparam logic [OP_W-1:0] OP_SETCNT = 3'd3;
  localparam logic [OP_W-1:0] OP_RSTCNT = 3'd4;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd5;

  // result kinds
  localparam logic [KIND_W-1:0] K_INSERTED  = 3'd0;
  localparam logic [KIND_W-1:0] K_DELETED   = 3'd1;
  localparam logic [KIND_W-1:0] K_TIMEOUT   = 3'd2;
  localparam logic [KIND_W-1:0] K_OVERRUN   = 3'd3;
  localparam logic [KIND_W-1:0] K_DONE_OK   = 3'd4;
  localparam logic [KIND_W-1:0] K_DONE_FAIL = 3'd5;

  // output register source select
  localparam logic [2:0] EM_NONE    = 3'd0;
  localparam logic [2:0] EM_INSERT  = 3'd1;
  localparam logic [2:0] EM_DELETE  = 3'd2;
  localparam logic [2:0] EM_OVERRUN = 3'd3;
  localparam logic [2:0] EM_TIMEOUT = 3'd4;
  localparam logic [2:0] EM_FINAL   = 3'd5;

  typedef struct packed {
    logic       load;        // capture an accepted request
    logic       ins_wr;      // write new slot at first free entry
    logic       del_wr;      // free the addressed slot
    logic       cnt_wr;      // set count / reset count write
    logic       walk_start;  // point the walk at slot 0
    logic       walk_upd;    // write back the ticked count
    logic       walk_next;   // step to the next slot
    logic       fin_load;    // capture the closing result
    logic [2:0] emit;        // load output register from this source
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ins_ok;
    logic            del_ok;
    logic            idx_ok;
    logic            ticks_zero;
    logic            walk_active;
    logic            walk_borrow;
    logic            walk_zero;
    logic            walk_last;
    logic            out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> design/ptsb_ifs.sv
// ----------------------------------------------------------------------------
// ptsb channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptsb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  event_id;
  logic [2:0]  slot_index;
  logic [31:0] reload_count;
  logic [31:0] elapsed_ticks;
  logic [31:0] count_value;

  modport source (output valid, output opcode, output event_id, output slot_index,
                  output reload_count, output elapsed_ticks, output count_value,
                  input ready);
  modport sink   (input valid, input opcode, input event_id, input slot_index,
                  input reload_count, input elapsed_ticks, input count_value,
                  output ready);
endinterface

interface ptsb_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [2:0] result_slot;
  logic [7:0] result_event;
  logic       last;

  modport source (output valid, output kind, output result_slot, output result_event,
                  output last, input ready);
  modport sink   (input valid, input kind, input result_slot, input result_event,
                  input last, output ready);
endinterface

`default_nettype wire

>>> design/ptsb_dp.sv
// ----------------------------------------------------------------------------
// ptsb_dp: slot storage, request registers and output register
// Holds the timer slots, the walk pointer, the closing result and the
// response register; executes commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ptsb_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ptsb_pkg::dp_cmd_t             cmd,
  output ptsb_pkg::dp_stat_t                 stat,
  input  wire logic [ptsb_pkg::OP_W-1:0]     opcode,
  input  wire logic [ptsb_pkg::EV_W-1:0]     event_id,
  input  wire logic [ptsb_pkg::IDX_W-1:0]    slot_index,
  input  wire logic [ptsb_pkg::CNT_W-1:0]    reload_count,
  input  wire logic [ptsb_pkg::CNT_W-1:0]    elapsed_ticks,
  input  wire logic [ptsb_pkg::CNT_W-1:0]    count_value,
  input  wire logic                          rsp_ready,
  output logic                               rsp_valid,
  output logic [ptsb_pkg::KIND_W-1:0]        kind,
  output logic [ptsb_pkg::IDX_W-1:0]         result_slot,
  output logic [ptsb_pkg::EV_W-1:0]          result_event,
  output logic                               last
);
  import ptsb_pkg::*;

  function automatic logic [IDX_W-1:0] first_set(input logic [SLOTS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  logic [EV_W-1:0]   slot_event  [SLOTS];
  logic [CNT_W-1:0]  slot_reload [SLOTS];
  logic [CNT_W-1:0]  slot_count  [SLOTS];

  logic [OP_W-1:0]   op;
  logic [EV_W-1:0]   op_ev;
  logic [CNT_W-1:0]  op_reload;
  logic [CNT_W-1:0]  op_ticks;
  logic [CNT_W-1:0]  op_cval;
  logic [IDX_W-1:0]  walk_idx;

  logic [KIND_W-1:0] fin_kind;
  logic [IDX_W-1:0]  fin_slot;
  logic [EV_W-1:0]   fin_event;

  logic [SLOTS-1:0]  match;
  logic [SLOTS-1:0]  free;
  logic [IDX_W-1:0]  match_idx;
  logic [IDX_W-1:0]  free_idx;
  logic [EV_W-1:0]   ev_rd;
  logic [CNT_W-1:0]  cnt_rd;
  logic [CNT_W-1:0]  rel_rd;
  logic [CNT_W:0]    diff;
  logic [CNT_W-1:0]  ins_reload;
  logic              idx_ok;
  logic              ins_ok;
  logic              look_ok;
  logic              del_ok;
  logic [KIND_W-1:0] fin_kind_next;
  logic [IDX_W-1:0]  fin_slot_next;
  logic [EV_W-1:0]   fin_event_next;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = (slot_event[i] == op_ev);
      free[i]  = (slot_event[i] == '0);
    end
  end

  assign match_idx  = first_set(match);
  assign free_idx   = first_set(free);
  assign ev_rd      = slot_event[walk_idx];
  assign cnt_rd     = slot_count[walk_idx];
  assign rel_rd     = slot_reload[walk_idx];
  assign diff       = {1'b0, cnt_rd} - {1'b0, op_ticks};
  assign ins_reload = (op_reload == '0) ? CNT_W'(1) : op_reload;
  assign idx_ok     = (32'(walk_idx) < 32'(SLOTS));
  assign ins_ok     = (op_ev != '0) && !(|match) && (|free);
  assign look_ok    = (op_ev != '0) && (|match);
  assign del_ok     = idx_ok && (ev_rd != '0);

  assign stat.op          = op;
  assign stat.ins_ok      = ins_ok;
  assign stat.del_ok      = del_ok;
  assign stat.idx_ok      = idx_ok;
  assign stat.ticks_zero  = (op_ticks == '0);
  assign stat.walk_active = (ev_rd != '0);
  assign stat.walk_borrow = diff[CNT_W];
  assign stat.walk_zero   = (diff[CNT_W-1:0] == '0);
  assign stat.walk_last   = (walk_idx == IDX_W'(SLOTS - 1));
  assign stat.out_free    = !rsp_valid || rsp_ready;

  // closing item, decided before the operation changes any slot
  always_comb begin
    fin_kind_next  = K_DONE_FAIL;
    fin_slot_next  = '0;
    fin_event_next = '0;
    case (op)
      OP_INSERT: begin
        if (ins_ok) begin
          fin_kind_next  = K_DONE_OK;
          fin_slot_next  = free_idx;
          fin_event_next = op_ev;
        end
      end
      OP_DELETE: begin
        if (del_ok) begin
          fin_kind_next  = K_DONE_OK;
          fin_slot_next  = walk_idx;
          fin_event_next = ev_rd;
        end
      end
      OP_TICK: begin
        fin_kind_next = K_DONE_OK;
      end
      OP_SETCNT, OP_RSTCNT: begin
        if (idx_ok) begin
          fin_kind_next  = K_DONE_OK;
          fin_slot_next  = walk_idx;
          fin_event_next = ev_rd;
        end
      end
      OP_LOOKUP: begin
        if (look_ok) begin
          fin_kind_next  = K_DONE_OK;
          fin_slot_next  = match_idx;
          fin_event_next = op_ev;
        end
      end
      default: begin
        fin_kind_next = K_DONE_FAIL;
      end
    endcase
  end

  // slot storage and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_event[i]  <= '0;
        slot_reload[i] <= '0;
        slot_count[i]  <= '0;
      end
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.ins_wr) begin
        slot_event[free_idx]  <= op_ev;
        slot_reload[free_idx] <= ins_reload;
        slot_count[free_idx]  <= ins_reload;
      end
      if (cmd.del_wr) slot_event[walk_idx] <= '0;
      if (cmd.cnt_wr) slot_count[walk_idx] <= (op == OP_SETCNT) ? op_cval : rel_rd;
      if (cmd.walk_upd) begin
        slot_count[walk_idx] <= (diff[CNT_W] || (diff[CNT_W-1:0] == '0)) ?
                                rel_rd : diff[CNT_W-1:0];
      end
      if (cmd.emit != EM_NONE) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request fields, walk pointer, closing item, response payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= opcode;
      op_ev     <= event_id;
      op_reload <= reload_count;
      op_ticks  <= elapsed_ticks;
      op_cval   <= count_value;
      walk_idx  <= slot_index;
    end else if (cmd.walk_start) begin
      walk_idx <= '0;
    end else if (cmd.walk_next) begin
      walk_idx <= walk_idx + IDX_W'(1);
    end
    if (cmd.fin_load) begin
      fin_kind  <= fin_kind_next;
      fin_slot  <= fin_slot_next;
      fin_event <= fin_event_next;
    end
    case (cmd.emit)
      EM_INSERT: begin
        kind <= K_INSERTED; result_slot <= free_idx; result_event <= op_ev; last <= 1'b0;
      end
      EM_DELETE: begin
        kind <= K_DELETED; result_slot <= walk_idx; result_event <= ev_rd; last <= 1'b0;
      end
      EM_OVERRUN: begin
        kind <= K_OVERRUN; result_slot <= walk_idx; result_event <= ev_rd; last <= 1'b0;
      end
      EM_TIMEOUT: begin
        kind <= K_TIMEOUT; result_slot <= walk_idx; result_event <= ev_rd; last <= 1'b0;
      end
      EM_FINAL: begin
        kind <= fin_kind; result_slot <= fin_slot; result_event <= fin_event; last <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/ptsb_ctrl.sv
// ----------------------------------------------------------------------------
// ptsb_ctrl: operation sequencer
// Accepts a request, runs its steps (slot walk for ticks) and issues
// each result transfer only when the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ptsb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    idle,
  input  wire ptsb_pkg::dp_stat_t stat,
  output ptsb_pkg::dp_cmd_t       cmd
);
  import ptsb_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_WALK    = 3'd2;
  localparam logic [2:0] S_WALK_TO = 3'd3;
  localparam logic [2:0] S_FINAL   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign idle = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.emit   = EM_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op == OP_INSERT && stat.ins_ok) begin
          if (stat.out_free) begin
            cmd.ins_wr   = 1'b1;
            cmd.fin_load = 1'b1;
            cmd.emit     = EM_INSERT;
            state_next   = S_FINAL;
          end
        end else if (stat.op == OP_DELETE && stat.del_ok) begin
          if (stat.out_free) begin
            cmd.del_wr   = 1'b1;
            cmd.fin_load = 1'b1;
            cmd.emit     = EM_DELETE;
            state_next   = S_FINAL;
          end
        end else if (stat.op == OP_TICK && !stat.ticks_zero) begin
          cmd.fin_load   = 1'b1;
          cmd.walk_start = 1'b1;
          state_next     = S_WALK;
        end else begin
          if ((stat.op == OP_SETCNT || stat.op == OP_RSTCNT) && stat.idx_ok) begin
            cmd.cnt_wr = 1'b1;
          end
          cmd.fin_load = 1'b1;
          state_next   = S_FINAL;
        end
      end
      S_WALK: begin
        if (!stat.walk_active) begin
          if (stat.walk_last) state_next = S_FINAL;
          else cmd.walk_next = 1'b1;
        end else if (stat.walk_borrow) begin
          // overrun: reload now, timeout follows in its own step
          if (stat.out_free) begin
            cmd.walk_upd = 1'b1;
            cmd.emit     = EM_OVERRUN;
            state_next   = S_WALK_TO;
          end
        end else if (stat.walk_zero) begin
          if (stat.out_free) begin
            cmd.walk_upd = 1'b1;
            cmd.emit     = EM_TIMEOUT;
            if (stat.walk_last) state_next = S_FINAL;
            else cmd.walk_next = 1'b1;
          end
        end else begin
          cmd.walk_upd = 1'b1;
          if (stat.walk_last) state_next = S_FINAL;
          else cmd.walk_next = 1'b1;
        end
      end
      S_WALK_TO: begin
        if (stat.out_free) begin
          cmd.emit = EM_TIMEOUT;
          if (stat.walk_last) begin
            state_next = S_FINAL;
          end else begin
            cmd.walk_next = 1'b1;
            state_next    = S_WALK;
          end
        end
      end
      S_FINAL: begin
        if (stat.out_free) begin
          cmd.emit   = EM_FINAL;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> design/periodic_timer_slot_bank_core.sv
// ----------------------------------------------------------------------------
// periodic_timer_slot_bank_core: bank of periodic timers
// Eight timer slots with insert, delete, tick, set count, reset count and
// lookup operations; each operation ends in one result with last set.
// ----------------------------------------------------------------------------
//
//  channel  modport   payload                                       role
//  -------  --------  --------------------------------------------  ----------
//  req      sink      opcode, event_id, slot_index, reload_count,   operation
//                     elapsed_ticks, count_value
//  rsp      source    kind, result_slot, result_event, last         results
//
//  One operation at a time. Insert, delete and lookup run as accept,
//  execute and closing result; set/reset count likewise.
//  A nonzero tick walks all 8 slots, one slot per cycle while no result waits
//  on a stalled rsp; each overrun adds a step that sends its timeout.
//  Reset (rst, synchronous) frees all slots and clears counts; no clearing
//  pass is needed, the bank is ready as soon as reset drops.
//  A stalled rsp holds the sequencer at its next result; req.ready is low
//  until the closing result has been loaded into the output register.
//
`default_nettype none

module periodic_timer_slot_bank_core (
  input  wire logic clk,
  input  wire logic rst,
  ptsb_req_if.sink  req,
  ptsb_rsp_if.source rsp
);
  import ptsb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     idle;

  // request is taken only between operations
  assign req.ready = idle;

  ptsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .idle      (idle),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slots, walk pointer and the output register that carries each transfer
  ptsb_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (req.opcode),
    .event_id      (req.event_id),
    .slot_index    (req.slot_index),
    .reload_count  (req.reload_count),
    .elapsed_ticks (req.elapsed_ticks),
    .count_value   (req.count_value),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .kind          (rsp.kind),
    .result_slot   (rsp.result_slot),
    .result_event  (rsp.result_event),
    .last          (rsp.last)
  );

endmodule

`default_nettype wire

>>> test/ptsb_timer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsb_timer_checker: result checker for the periodic timer slot bank
// Watches the request and response channels, keeps its own copy of the slot
// bank, predicts the result items of each operation and compares them in
// order with what the core returns.
// ----------------------------------------------------------------------------

module ptsb_timer_checker (
  input  wire logic clk,
  input  wire logic rst,
  ptsb_req_if       req,
  ptsb_rsp_if       rsp,
  output int        fail_count,
  output int        results_due
);
  import ptsb_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  slot;
    logic [EV_W-1:0]   ev;
    logic              last;
  } timer_result_t;

  logic [EV_W-1:0]  bank_event  [SLOTS];
  logic [CNT_W-1:0] bank_reload [SLOTS];
  logic [CNT_W-1:0] bank_count  [SLOTS];

  timer_result_t pending_results[$];
  int            fails = 0;
  int            due   = 0;

  assign fail_count  = fails;
  assign results_due = due;

  function automatic int first_slot_holding(input logic [EV_W-1:0] ev);
    for (int i = 0; i < SLOTS; i++) begin
      if (bank_event[i] == ev) return i;
    end
    return -1;
  endfunction

  task automatic note_result(input logic [KIND_W-1:0] kind, input int slot,
                             input logic [EV_W-1:0] ev, input logic last);
    timer_result_t r;
    r.kind = kind;
    r.slot = slot[IDX_W-1:0];
    r.ev   = ev;
    r.last = last;
    pending_results.push_back(r);
  endtask

  // bank update and result prediction for one accepted operation
  task automatic apply_timer_op();
    logic [OP_W-1:0]  op;
    logic [EV_W-1:0]  ev;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] ticks;
    int               hit;
    int               free_slot;
    op     = req.opcode;
    ev     = req.event_id;
    idx    = req.slot_index;
    period = (req.reload_count == '0) ? CNT_W'(1) : req.reload_count;
    ticks  = req.elapsed_ticks;
    case (op)
      OP_INSERT: begin
        hit       = first_slot_holding(ev);
        free_slot = first_slot_holding('0);
        if (ev == '0 || hit >= 0 || free_slot < 0) begin
          note_result(K_DONE_FAIL, 0, '0, 1'b1);
        end else begin
          bank_event[free_slot]  = ev;
          bank_reload[free_slot] = period;
          bank_count[free_slot]  = period;
          note_result(K_INSERTED, free_slot, ev, 1'b0);
          note_result(K_DONE_OK, free_slot, ev, 1'b1);
        end
      end
      OP_DELETE: begin
        if (int'(idx) >= SLOTS || bank_event[idx] == '0) begin
          note_result(K_DONE_FAIL, 0, '0, 1'b1);
        end else begin
          ev = bank_event[idx];
          bank_event[idx] = '0;
          note_result(K_DELETED, int'(idx), ev, 1'b0);
          note_result(K_DONE_OK, int'(idx), ev, 1'b1);
        end
      end
      OP_TICK: begin
        if (ticks != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (bank_event[i] != '0) begin
              if (bank_count[i] >= ticks) begin
                bank_count[i] = bank_count[i] - ticks;
                if (bank_count[i] == '0) begin
                  bank_count[i] = bank_reload[i];
                  note_result(K_TIMEOUT, i, bank_event[i], 1'b0);
                end
              end else begin
                bank_count[i] = bank_reload[i];
                note_result(K_OVERRUN, i, bank_event[i], 1'b0);
                note_result(K_TIMEOUT, i, bank_event[i], 1'b0);
              end
            end
          end
        end
        note_result(K_DONE_OK, 0, '0, 1'b1);
      end
      OP_SETCNT, OP_RSTCNT: begin
        if (int'(idx) >= SLOTS) begin
          note_result(K_DONE_FAIL, 0, '0, 1'b1);
        end else begin
          bank_count[idx] = (op == OP_SETCNT) ? req.count_value : bank_reload[idx];
          note_result(K_DONE_OK, int'(idx), bank_event[idx], 1'b1);
        end
      end
      OP_LOOKUP: begin
        hit = first_slot_holding(ev);
        if (ev == '0 || hit < 0) note_result(K_DONE_FAIL, 0, '0, 1'b1);
        else                     note_result(K_DONE_OK, hit, ev, 1'b1);
      end
      default: begin
        note_result(K_DONE_FAIL, 0, '0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        bank_event[i]  = '0;
        bank_reload[i] = '0;
        bank_count[i]  = '0;
      end
      pending_results.delete();
    end else begin
      // results first: a result at this edge never belongs to the request
      // accepted at the same edge
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          fails++;
          $display("%0t ptsb check: unexpected result kind %0d slot %0d event %0d last %0d",
                   $time, rsp.kind, rsp.result_slot, rsp.result_event, rsp.last);
        end else begin
          want = pending_results.pop_front();
          if (rsp.kind !== want.kind || rsp.result_slot !== want.slot ||
              rsp.result_event !== want.ev || rsp.last !== want.last) begin
            fails++;
            $display("%0t ptsb check: expected kind %0d slot %0d event %0d last %0d,",
                     $time, want.kind, want.slot, want.ev, want.last,
                     " got kind %0d slot %0d event %0d last %0d",
                     rsp.kind, rsp.result_slot, rsp.result_event, rsp.last);
          end
        end
      end
      if (req.valid && req.ready) apply_timer_op();
    end
    due = pending_results.size();
  end

endmodule

>>> test/tb_periodic_timer_slot_bank_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_timer_slot_bank_core: testbench for the timer slot bank core
// Drives directed and random timer operations into the core under several
// idle/stall mixes; the checker beside the core predicts and compares every
// result transfer, and this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_periodic_timer_slot_bank_core;
  import ptsb_pkg::*;

  // opcodes the core must reject
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  // a tick with all slots overrunning is 17 results; even with the receiver
  // stalling 67 percent of the time, no transfer for this long means a hang
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_TIME  = 24;   // closing cycles after the last result
  localparam int PHASE_ITEMS  = 70;   // four phases; with the directed ops about 310 items

  logic clk;
  logic rst;
  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  int   quiet_cycles       = 0;
  int   fail_count;
  int   results_due;

  ptsb_req_if req_ch ();
  ptsb_rsp_if rsp_ch ();

  periodic_timer_slot_bank_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ptsb_timer_checker timer_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: counts cycles in which neither channel completes a transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver side: ready redrawn at every falling edge from the stall mix
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // One operation: optional idle gap, then hold valid until the transfer.
  // Called and returning at a falling edge; valid stays high into the next
  // call when no gap is drawn.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [EV_W-1:0] ev,
                         input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] period,
                         input logic [CNT_W-1:0] ticks, input logic [CNT_W-1:0] cval);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid         = 1'b1;
    req_ch.opcode        = op;
    req_ch.event_id      = ev;
    req_ch.slot_index    = idx;
    req_ch.reload_count  = period;
    req_ch.elapsed_ticks = ticks;
    req_ch.count_value   = cval;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // hold off the sender until every predicted result has been seen
  task automatic drain_results();
    req_ch.valid = 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // Random operation. Event ids come mostly from a small pool so inserts
  // collide, lookups hit and the bank fills up; periods and ticks are mostly
  // small so timeouts and overruns happen, with full-width values mixed in.
  task automatic send_random_op();
    int               pick;
    logic [OP_W-1:0]  op;
    logic [EV_W-1:0]  ev;
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] ticks;
    logic [CNT_W-1:0] cval;
    pick = $urandom_range(99);
    if      (pick < 26) op = OP_INSERT;
    else if (pick < 38) op = OP_DELETE;
    else if (pick < 68) op = OP_TICK;
    else if (pick < 76) op = OP_SETCNT;
    else if (pick < 84) op = OP_RSTCNT;
    else if (pick < 95) op = OP_LOOKUP;
    else                op = $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;

    pick = $urandom_range(99);
    if      (pick < 4)  ev = '0;
    else if (pick < 14) ev = EV_W'($urandom_range(255));
    else                ev = EV_W'($urandom_range(12, 1));

    pick = $urandom_range(99);
    if      (pick < 5)  period = '0;
    else if (pick < 15) period = $urandom;
    else                period = $urandom_range(6, 1);

    pick = $urandom_range(99);
    if      (pick < 5)  ticks = '0;
    else if (pick < 18) ticks = $urandom;
    else                ticks = $urandom_range(4, 1);

    pick = $urandom_range(99);
    if      (pick < 15) cval = $urandom;
    else                cval = $urandom_range(8);

    send_op(op, ev, IDX_W'($urandom_range(SLOTS - 1)), period, ticks, cval);
  endtask

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.opcode        = OP_INSERT;
    req_ch.event_id      = '0;
    req_ch.slot_index    = '0;
    req_ch.reload_count  = '0;
    req_ch.elapsed_ticks = '0;
    req_ch.count_value   = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part, no idling ---
    // empty bank: lookups and slot ops on free slots
    send_op(OP_LOOKUP,   8'd0,   3'd0, '0, '0, '0);             // id none
    send_op(OP_LOOKUP,   8'd9,   3'd0, '0, '0, '0);             // not present
    send_op(OP_DELETE,   8'd0,   3'd3, '0, '0, '0);             // free slot
    send_op(OP_SETCNT,   8'd0,   3'd5, '0, '0, 32'hFFFF_FFFF);  // free slot still written
    send_op(OP_RSTCNT,   8'd0,   3'd7, '0, '0, '0);
    send_op(OP_TICK,     8'd0,   3'd0, '0, '0, '0);             // zero ticks
    send_op(OP_TICK,     8'd0,   3'd0, '0, 32'd1, '0);          // nothing active
    send_op(OP_UNUSED_6, 8'hFF,  3'd7, '1, '1, '1);
    send_op(OP_UNUSED_7, 8'h01,  3'd0, '0, '0, '0);
    // inserts: id none, period zero taken as one, widest period, duplicate
    send_op(OP_INSERT,   8'd0,   3'd0, 32'd5, '0, '0);
    send_op(OP_INSERT,   8'd255, 3'd0, 32'd0, '0, '0);
    send_op(OP_INSERT,   8'd1,   3'd0, 32'hFFFF_FFFF, '0, '0);
    send_op(OP_INSERT,   8'd128, 3'd0, 32'd3, '0, '0);
    send_op(OP_INSERT,   8'd255, 3'd0, 32'd7, '0, '0);
    send_op(OP_LOOKUP,   8'd128, 3'd0, '0, '0, '0);
    // one tick times out the period-one slot; max ticks overruns everything
    send_op(OP_TICK,     8'd0,   3'd0, '0, 32'd1, '0);
    send_op(OP_TICK,     8'd0,   3'd0, '0, 32'hFFFF_FFFF, '0);
    send_op(OP_SETCNT,   8'd0,   3'd1, '0, '0, 32'd0);          // count zero: next tick overruns
    send_op(OP_RSTCNT,   8'd0,   3'd2, '0, '0, '0);
    // fill the bank, then an insert with no free slot
    send_op(OP_INSERT,   8'd2,   3'd0, 32'd2, '0, '0);
    send_op(OP_INSERT,   8'd4,   3'd0, 32'd2, '0, '0);
    send_op(OP_INSERT,   8'd8,   3'd0, 32'd2, '0, '0);
    send_op(OP_INSERT,   8'd16,  3'd0, 32'd2, '0, '0);
    send_op(OP_INSERT,   8'd32,  3'd0, 32'd2, '0, '0);
    send_op(OP_INSERT,   8'd64,  3'd0, 32'd2, '0, '0);
    // full bank, every slot overruns: longest result burst
    send_op(OP_TICK,     8'd0,   3'd0, '0, 32'hFFFF_FFFF, '0);
    send_op(OP_DELETE,   8'd0,   3'd7, '0, '0, '0);
    send_op(OP_DELETE,   8'd0,   3'd0, '0, '0, '0);
    drain_results();

    // --- random part: one phase per idle/stall mix ---
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
        default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_op();
        // now and then let the core run completely dry mid-phase
        if ($urandom_range(99) < 3) drain_results();
      end
      drain_results();
    end

    req_ch.valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_TIME) @(posedge clk);

    if (fail_count == 0 && results_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
